/* rtl/core/jdpm_pkg.sv */
// package for the joystick drive-mode pwm mapper
// types, codes, widths and reset values shared by the rtl/core modules except jdpm_div
// no dependencies
package jdpm_pkg;

  localparam int unsigned AxisBitsDefault = 16;
  localparam int unsigned AxisW           = 16;
  localparam int unsigned DeadzoneW       = 15;
  localparam int unsigned PulseW          = 12;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 15;
  localparam int unsigned DivDividendW    = 31;
  localparam int unsigned DivDivisorW     = 16;

  localparam logic [DeadzoneW-1:0] DeadzoneReset = 15'd3277;
  localparam logic [PulseW-1:0]    PulseMinReset = 12'd1000;
  localparam logic [PulseW-1:0]    PulseMaxReset = 12'd2000;

  localparam logic [CfgIdxW-1:0] CfgDeadzone = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseMin = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseMax = 2'd2;

  typedef enum logic [1:0] {
    ActUpdate = 2'd0,
    ActSwitch = 2'd1,
    ActBrake  = 2'd2,
    ActBegin  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ModeInit     = 2'd0,
    ModeCar      = 2'd1,
    ModeTank     = 2'd2,
    ModeFailsafe = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindNeutral = 2'd1,
    KindCar     = 2'd2,
    KindTank    = 2'd3
  } kind_e;

  typedef struct packed {
    logic  capture;
    logic  dz_load;
    logic  sel_x;
    logic  div_start;
    logic  div_map;
    logic  dz_fin;
    logic  mul;
    logic  map_fin;
    logic  dst_second;
    logic  dup;
    logic  out_load;
    kind_e out_kind;
    mode_e out_mode;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

/* rtl/core/joystick_drive_mode_pwm_mapper_core.sv */
// per mapped axis: a 31-step radix-2 deadzone divider, then a fold loop for the map division;
// car items map both axes, tank items map one, and items of other kinds map no axis
// one item at a time; the next item is taken while the last result waits at the output
// reset is asynchronous active low: mode init, no pending switch, config at defaults
// top level of the joystick drive-mode pwm mapper; uses jdpm_pkg, jdpm_ctrl, jdpm_dp
module joystick_drive_mode_pwm_mapper_core #(
  parameter int unsigned AXIS_BITS = jdpm_pkg::AxisBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // axis_x, axis_y
  input  logic [2:0]  s_axis_tuser_i,  // action, pad_present
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // first_pulse_us, second_pulse_us, mode_now, zero fill
  output logic [1:0]  m_axis_tuser_o   // drive_kind
);

  jdpm_pkg::cmd_t  cmd;
  jdpm_pkg::stat_t stat;
  jdpm_pkg::kind_e kind;
  jdpm_pkg::mode_e mode;
  logic [11:0]     first_pulse;
  logic [11:0]     second_pulse;

  jdpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .action_i    (jdpm_pkg::action_e'(s_axis_tuser_i[1:0])),
    .pad_i       (s_axis_tuser_i[2]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jdpm_dp #(
    .AXIS_BITS (AXIS_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .axis_x_i          (s_axis_tdata_i[15:0]),
    .axis_y_i          (s_axis_tdata_i[31:16]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .first_pulse_us_o  (first_pulse),
    .second_pulse_us_o (second_pulse),
    .drive_kind_o      (kind),
    .mode_now_o        (mode)
  );

  assign m_axis_tdata_o = {6'd0, mode, second_pulse, first_pulse};
  assign m_axis_tuser_o = kind;

  a_pulses_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != jdpm_pkg::KindCar
      && m_axis_tuser_o != jdpm_pkg::KindTank |-> m_axis_tdata_o[23:0] == 24'd0)
    else $error("pulses not zero without a motor command");

  a_tank_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == jdpm_pkg::KindTank
      |-> m_axis_tdata_o[11:0] == m_axis_tdata_o[23:12])
    else $error("tank sides differ");

  a_kind_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == jdpm_pkg::KindCar
      || m_axis_tuser_o == jdpm_pkg::KindTank)
      |-> m_axis_tdata_o[25:24] == (m_axis_tuser_o - 2'd1))
    else $error("drive command does not match mode");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

endmodule

/* rtl/core/jdpm_div.sv */
// iterative restoring divider, one quotient bit per cycle
// unsigned operands, registered quotient; no package dependencies
module jdpm_div #(
  parameter int unsigned DVD_W = 31,
  parameter int unsigned DVR_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVR_W-1:0] rem_q;
  logic [DVR_W-1:0] dvr_q;

  logic [DVR_W:0]   rem_sh;
  logic [DVR_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvr_q};
  assign ge     = ~diff[DVR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVR_W-1:0] : rem_sh[DVR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

/* rtl/core/jdpm_dp.sv */
// datapath: config registers, axis deadzone and pulse mapping, output register
// uses jdpm_pkg and jdpm_div
module jdpm_dp #(
  parameter int unsigned AXIS_BITS = jdpm_pkg::AxisBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jdpm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [jdpm_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [jdpm_pkg::AxisW-1:0]         axis_x_i,
  input  logic [jdpm_pkg::AxisW-1:0]         axis_y_i,
  input  jdpm_pkg::cmd_t                     cmd_i,
  output jdpm_pkg::stat_t                    stat_o,
  output logic [jdpm_pkg::PulseW-1:0]        first_pulse_us_o,
  output logic [jdpm_pkg::PulseW-1:0]        second_pulse_us_o,
  output jdpm_pkg::kind_e                    drive_kind_o,
  output jdpm_pkg::mode_e                    mode_now_o
);

  localparam int unsigned DvdW = jdpm_pkg::DivDividendW;
  localparam int unsigned DvrW = jdpm_pkg::DivDivisorW;
  localparam int unsigned PW   = jdpm_pkg::PulseW;

  localparam logic [15:0] AxisFull   = 16'((32'd1 << (AXIS_BITS - 1)) - 32'd1);
  localparam logic [16:0] AxisFullP1 = {1'b0, AxisFull} + 17'd1;
  localparam logic [15:0] MapDivisor = 16'((32'd1 << AXIS_BITS) - 32'd1);
  localparam logic [DvdW-1:0] MapMask = DvdW'(MapDivisor);
  localparam logic signed [16:0] SatHi = $signed({1'b0, AxisFull});
  localparam logic signed [16:0] SatLo = -SatHi - 17'sd1;

  logic [jdpm_pkg::DeadzoneW-1:0] dz_q;
  logic [PW-1:0]                  pmin_q;
  logic [PW-1:0]                  pmax_q;

  logic [15:0]     ax_q, ay_q;
  logic [29:0]     tf_q;
  logic [DvdW-1:0] num_q;
  logic            neg_q;
  logic [15:0]     u_q;
  logic [DvdW-1:0] pmag_q;
  logic            pneg_q;
  logic [PW-1:0]   first_q, second_q;
  logic [PW-1:0]   out_first_q, out_second_q;
  jdpm_pkg::kind_e out_kind_q;
  jdpm_pkg::mode_e out_mode_q;
  logic [DvdW-1:0] fx_q;
  logic [PW-1:0]   fq_q;
  logic            fbusy_q;
  logic            fdone_q;

  logic [29:0]        tf_d;
  logic [15:0]        v_sel;
  logic signed [16:0] ve, vs;
  logic [16:0]        magw;
  logic [DvdW-1:0]    scaled;
  logic               in_zone;
  logic [DvdW-1:0]    num_d;
  logic [DvrW-1:0]    dz_div;
  logic               div_go;
  logic               fold_go;
  logic               div_done;
  logic [DvdW-1:0]    quot;
  logic [DvdW-1:0]    f_hi;
  logic [DvdW-1:0]    f_lo;
  logic [15:0]        lim;
  logic [15:0]        qsat;
  logic [15:0]        u_d;
  logic signed [12:0] span;
  logic signed [29:0] prod;
  logic [29:0]        prod_mag;
  logic [PW-1:0]      q12;
  logic [PW-1:0]      pulse;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= jdpm_pkg::DeadzoneReset;
      pmin_q <= jdpm_pkg::PulseMinReset;
      pmax_q <= jdpm_pkg::PulseMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jdpm_pkg::CfgDeadzone: dz_q   <= cfg_data_i;
        jdpm_pkg::CfgPulseMin: pmin_q <= cfg_data_i[PW-1:0];
        jdpm_pkg::CfgPulseMax: pmax_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // deadzone numerator
  assign tf_d  = {15'd0, dz_q} * {15'd0, AxisFull[14:0]};
  assign v_sel = cmd_i.sel_x ? ax_q : ay_q;
  assign ve    = $signed({v_sel[15], v_sel});

  always_comb begin
    if (ve > SatHi) begin
      vs = SatHi;
    end else if (ve < SatLo) begin
      vs = SatLo;
    end else begin
      vs = ve;
    end
  end

  assign magw    = vs[16] ? 17'(-vs) : 17'(vs);
  assign scaled  = {magw[15:0], 15'd0};
  assign in_zone = scaled < {1'b0, tf_q};
  assign num_d   = in_zone ? '0 : scaled - {1'b0, tf_q};

  // deadzone divider
  assign dz_div  = 16'(17'd32768 - {2'b00, dz_q});
  assign div_go  = cmd_i.div_start && !cmd_i.div_map;
  assign fold_go = cmd_i.div_start && cmd_i.div_map;

  jdpm_div #(
    .DVD_W (DvdW),
    .DVR_W (DvrW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (num_q),
    .divisor_i  (dz_div),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // map division by 2^AXIS_BITS - 1: fold high part onto low part until it fits
  assign f_hi = fx_q >> AXIS_BITS;
  assign f_lo = fx_q & MapMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbusy_q <= 1'b0;
      fdone_q <= 1'b0;
    end else if (fold_go) begin
      fbusy_q <= 1'b1;
      fdone_q <= 1'b0;
    end else if (fbusy_q && (f_hi == '0)) begin
      fbusy_q <= 1'b0;
      fdone_q <= 1'b1;
    end else begin
      fdone_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_go) begin
      fx_q <= pmag_q;
      fq_q <= '0;
    end else if (fbusy_q) begin
      if (f_hi != '0) begin
        fq_q <= fq_q + f_hi[PW-1:0];
        fx_q <= f_hi + f_lo;
      end else if (f_lo == MapMask) begin
        fq_q <= fq_q + PW'(1);
        fx_q <= '0;
      end
    end
  end

  assign stat_o.div_done = div_done || fdone_q;

  // saturate and offset to unsigned map input
  assign lim  = neg_q ? AxisFullP1[15:0] : AxisFull;
  assign qsat = (quot > {15'd0, lim}) ? lim : quot[15:0];
  assign u_d  = neg_q ? (AxisFullP1[15:0] - qsat) : (AxisFullP1[15:0] + qsat);

  // linear map
  assign span     = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign prod     = $signed({1'b0, u_q}) * span;
  assign prod_mag = prod[29] ? 30'(-prod) : 30'(prod);
  assign q12      = fq_q;
  assign pulse    = (pneg_q ? (PW'(0) - q12) : q12) + pmin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q     <= axis_x_i;
      ay_q     <= axis_y_i;
      tf_q     <= tf_d;
      first_q  <= '0;
      second_q <= '0;
    end
    if (cmd_i.dz_load) begin
      num_q <= num_d;
      neg_q <= vs[16];
    end
    if (cmd_i.dz_fin) begin
      u_q <= u_d;
    end
    if (cmd_i.mul) begin
      pmag_q <= {1'b0, prod_mag};
      pneg_q <= prod[29];
    end
    if (cmd_i.map_fin) begin
      if (cmd_i.dst_second || cmd_i.dup) begin
        second_q <= pulse;
      end
      if (!cmd_i.dst_second) begin
        first_q <= pulse;
      end
    end
    if (cmd_i.out_load) begin
      out_first_q  <= first_q;
      out_second_q <= second_q;
      out_kind_q   <= cmd_i.out_kind;
      out_mode_q   <= cmd_i.out_mode;
    end
  end

  assign first_pulse_us_o  = out_first_q;
  assign second_pulse_us_o = out_second_q;
  assign drive_kind_o      = out_kind_q;
  assign mode_now_o        = out_mode_q;

endmodule

/* rtl/core/jdpm_ctrl.sv */
// controller: drive mode, switch request and the per-item sequence
// uses jdpm_pkg; drives the datapath through cmd_t, reads stat_t
module jdpm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jdpm_pkg::action_e action_i,
  input  logic              pad_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  jdpm_pkg::stat_t   stat_i,
  output jdpm_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StDzStart,
    StDzWait,
    StDzFin,
    StMul,
    StMapStart,
    StMapWait,
    StMapFin,
    StEmit
  } state_e;

  state_e          state_q;
  jdpm_pkg::mode_e mode_q;
  logic            pend_q;
  jdpm_pkg::kind_e kind_q;
  logic            sel_x_q;
  logic            out_valid_q;

  jdpm_pkg::mode_e mode_nx;
  logic            pend_nx;
  jdpm_pkg::kind_e kind_nx;
  logic            accept;
  logic            emit;

  assign accept = in_valid_i && (state_q == StIdle);
  assign emit   = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    mode_nx = mode_q;
    pend_nx = pend_q;
    kind_nx = jdpm_pkg::KindNone;
    unique case (action_i)
      jdpm_pkg::ActSwitch: begin
        if (mode_q != jdpm_pkg::ModeFailsafe) begin
          pend_nx = 1'b1;
        end
      end
      jdpm_pkg::ActBrake: begin
        kind_nx = jdpm_pkg::KindNeutral;
      end
      jdpm_pkg::ActBegin: begin
        mode_nx = jdpm_pkg::ModeCar;
      end
      jdpm_pkg::ActUpdate: begin
        if (pend_q) begin
          mode_nx = (mode_q == jdpm_pkg::ModeCar) ? jdpm_pkg::ModeTank : jdpm_pkg::ModeCar;
          pend_nx = 1'b0;
        end
        priority if (!pad_i) begin
          mode_nx = jdpm_pkg::ModeFailsafe;
          kind_nx = jdpm_pkg::KindNeutral;
        end else if (mode_nx == jdpm_pkg::ModeCar) begin
          kind_nx = jdpm_pkg::KindCar;
        end else if (mode_nx == jdpm_pkg::ModeTank) begin
          kind_nx = jdpm_pkg::KindTank;
        end else begin
          mode_nx = jdpm_pkg::ModeFailsafe;
          kind_nx = jdpm_pkg::KindNeutral;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= jdpm_pkg::ModeInit;
      pend_q      <= 1'b0;
      kind_q      <= jdpm_pkg::KindNone;
      sel_x_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            mode_q  <= mode_nx;
            pend_q  <= pend_nx;
            kind_q  <= kind_nx;
            sel_x_q <= 1'b0;
            if (kind_nx == jdpm_pkg::KindCar || kind_nx == jdpm_pkg::KindTank) begin
              state_q <= StLoad;
            end else begin
              state_q <= StEmit;
            end
          end
        end
        StLoad:     state_q <= StDzStart;
        StDzStart:  state_q <= StDzWait;
        StDzWait: begin
          if (stat_i.div_done) begin
            state_q <= StDzFin;
          end
        end
        StDzFin:    state_q <= StMul;
        StMul:      state_q <= StMapStart;
        StMapStart: state_q <= StMapWait;
        StMapWait: begin
          if (stat_i.div_done) begin
            state_q <= StMapFin;
          end
        end
        StMapFin: begin
          if (kind_q == jdpm_pkg::KindCar && !sel_x_q) begin
            sel_x_q <= 1'b1;
            state_q <= StLoad;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = accept;
    cmd_o.dz_load    = (state_q == StLoad);
    cmd_o.sel_x      = sel_x_q;
    cmd_o.div_start  = (state_q == StDzStart) || (state_q == StMapStart);
    cmd_o.div_map    = (state_q == StMapStart);
    cmd_o.dz_fin     = (state_q == StDzFin);
    cmd_o.mul        = (state_q == StMul);
    cmd_o.map_fin    = (state_q == StMapFin);
    cmd_o.dst_second = sel_x_q;
    cmd_o.dup        = (kind_q == jdpm_pkg::KindTank);
    cmd_o.out_load   = emit;
    cmd_o.out_kind   = kind_q;
    cmd_o.out_mode   = mode_q;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* dv/tb_top.sv */
// testbench for joystick_drive_mode_pwm_mapper_core: directed and random stick transactions
// a scoreboard class predicts mode, kind and pulse widths and checks every result in order
// depends on jdpm_pkg and the rtl/core sources
module tb_top;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned HoldAfter  = 300;
  localparam int unsigned PhaseItems = 230;
  localparam int unsigned NumPhases  = 6;
  localparam longint      AxisFull   = 32767;

  typedef struct packed {
    jdpm_pkg::kind_e kind;
    logic [11:0]     first_us;
    logic [11:0]     second_us;
    jdpm_pkg::mode_e mode;
  } drive_cmd_t;

  class drive_scoreboard;
    logic [14:0]     dz_level;
    logic [11:0]     pulse_lo;
    logic [11:0]     pulse_hi;
    jdpm_pkg::mode_e mode;
    bit              switch_req;
    drive_cmd_t      expected_q[$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
      dz_level   = jdpm_pkg::DeadzoneReset;
      pulse_lo   = jdpm_pkg::PulseMinReset;
      pulse_hi   = jdpm_pkg::PulseMaxReset;
      mode       = jdpm_pkg::ModeInit;
      switch_req = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] data);
      case (idx)
        jdpm_pkg::CfgDeadzone: dz_level = data;
        jdpm_pkg::CfgPulseMin: pulse_lo = data[11:0];
        jdpm_pkg::CfgPulseMax: pulse_hi = data[11:0];
        default: ;
      endcase
    endfunction

    function logic [11:0] axis_pulse(logic [15:0] raw);
      longint v, mag, t, d, lo, hi, p;
      v   = longint'(signed'(raw));
      t   = longint'(dz_level);
      mag = (v < 0) ? -v : v;
      // rescaling deadzone
      if (mag * 32768 < t * AxisFull) begin
        d = 0;
      end else begin
        d = (mag * 32768 - t * AxisFull) / (32768 - t);
        if (v < 0) d = -d;
        if (d > AxisFull) d = AxisFull;
        if (d < -AxisFull - 1) d = -AxisFull - 1;
      end
      lo = longint'(pulse_lo);
      hi = longint'(pulse_hi);
      p  = (d + AxisFull + 1) * (hi - lo) / (2 * AxisFull + 1) + lo;
      return p[11:0];
    endfunction

    function void note_item(jdpm_pkg::action_e act, logic pad, logic [15:0] ax,
                            logic [15:0] ay);
      drive_cmd_t c;
      c.kind      = jdpm_pkg::KindNone;
      c.first_us  = '0;
      c.second_us = '0;
      c.mode      = jdpm_pkg::ModeInit;
      case (act)
        jdpm_pkg::ActSwitch: if (mode != jdpm_pkg::ModeFailsafe) switch_req = 1'b1;
        jdpm_pkg::ActBrake:  c.kind = jdpm_pkg::KindNeutral;
        jdpm_pkg::ActBegin:  mode = jdpm_pkg::ModeCar;
        default: begin
          if (switch_req) begin
            mode       = (mode == jdpm_pkg::ModeCar) ? jdpm_pkg::ModeTank : jdpm_pkg::ModeCar;
            switch_req = 1'b0;
          end
          if (pad && mode == jdpm_pkg::ModeCar) begin
            c.kind      = jdpm_pkg::KindCar;
            c.first_us  = axis_pulse(ay);
            c.second_us = axis_pulse(ax);
          end else if (pad && mode == jdpm_pkg::ModeTank) begin
            c.kind      = jdpm_pkg::KindTank;
            c.first_us  = axis_pulse(ay);
            c.second_us = c.first_us;
          end else begin
            mode   = jdpm_pkg::ModeFailsafe;
            c.kind = jdpm_pkg::KindNeutral;
          end
        end
      endcase
      c.mode = mode;
      expected_q.push_back(c);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] user);
      drive_cmd_t c;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none actual tdata %h tuser %h",
                 $time, data, user);
        return;
      end
      c = expected_q.pop_front();
      compare_field("drive_kind", c.kind, user);
      compare_field("first_pulse_us", c.first_us, data[11:0]);
      compare_field("second_pulse_us", c.second_us, data[23:12]);
      compare_field("mode_now", c.mode, data[25:24]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [14:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  bit              tx_gaps = 1'b0;
  bit              rx_gaps = 1'b0;
  int unsigned     idle_cycles = 0;
  drive_scoreboard board;

  always #5 clk_i = ~clk_i;

  joystick_drive_mode_pwm_mapper_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic int unsigned idle_len(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_axis();
    int unsigned sel;
    longint      thr;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom);
    if (sel < 7) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        3:       return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    // around the deadzone threshold
    thr = (longint'(board.dz_level) * AxisFull + 32767) / 32768
          + longint'($urandom_range(0, 2)) - 1;
    if (thr > AxisFull) thr = AxisFull;
    if (thr < 0) thr = 0;
    return ($urandom_range(0, 1) != 0) ? 16'(thr) : 16'(-thr);
  endfunction

  task automatic send_item(jdpm_pkg::action_e act, logic pad, logic [15:0] ax,
                           logic [15:0] ay);
    int unsigned gap;
    gap = idle_len(tx_gaps);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {ay, ax};
    s_tuser  = {pad, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_item(act, pad, ax, ay);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [14:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic apply_setting(int unsigned phase);
    logic [14:0] dz;
    logic [11:0] lo, hi;
    case (phase)
      1: begin dz = 15'd0;     lo = 12'd0;    hi = 12'd4095; end
      2: begin dz = 15'd32767; lo = 12'd4095; hi = 12'd0;    end
      3: begin dz = 15'd32766; lo = 12'($urandom); hi = lo;  end
      5: begin dz = 15'd3277;  lo = 12'd1000; hi = 12'd2000; end
      default: begin
        dz = 15'($urandom);
        lo = 12'($urandom);
        hi = 12'($urandom);
      end
    endcase
    write_cfg(jdpm_pkg::CfgDeadzone, dz);
    write_cfg(jdpm_pkg::CfgPulseMin, {3'b000, lo});
    write_cfg(jdpm_pkg::CfgPulseMax, {3'b000, hi});
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) board.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls and one long hold-off so the block backs up
  initial begin
    bit          held;
    int unsigned len;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && board.checked >= HoldAfter) begin
        held     = 1'b1;
        m_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        len = idle_len(1'b1);
        if (len == 0) len = 1;
        m_tready = 1'b0;
        repeat (len) @(negedge clk_i);
      end
      m_tready = 1'b1;
    end
  end

  initial begin
    jdpm_pkg::action_e act;
    logic              pad;
    int unsigned       r;
    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // update while in init, failsafe handling, car and tank, switch requests
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h7fff, 16'h8000);
    send_item(jdpm_pkg::ActSwitch, 1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h1234, 16'h4321);
    send_item(jdpm_pkg::ActBegin,  1'b0, 16'hffff, 16'hffff);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h8000, 16'h7fff);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'hffff, 16'h0001);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'd3277, 16'd3276);
    send_item(jdpm_pkg::ActUpdate, 1'b1, -16'sd3277, -16'sd3276);
    send_item(jdpm_pkg::ActSwitch, 1'b0, 16'h5555, 16'haaaa);
    send_item(jdpm_pkg::ActBrake,  1'b1, 16'h7fff, 16'h7fff);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h0000, 16'h7fff);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h7fff, 16'h8000);
    send_item(jdpm_pkg::ActSwitch, 1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActUpdate, 1'b0, 16'h7fff, 16'h7fff);
    send_item(jdpm_pkg::ActBegin,  1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActSwitch, 1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActBegin,  1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'h4000, 16'hc000);
    send_item(jdpm_pkg::ActSwitch, 1'b1, 16'h0000, 16'h0000);
    send_item(jdpm_pkg::ActUpdate, 1'b1, 16'hc000, 16'h4000);

    for (int unsigned phase = 1; phase <= NumPhases; phase++) begin
      wait_drained();
      apply_setting(phase);
      tx_gaps = (phase != 4) && ($urandom_range(0, 3) != 0);
      rx_gaps = (phase != 4) && ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        r = $urandom_range(0, 99);
        if (r < 65) act = jdpm_pkg::ActUpdate;
        else if (r < 80) act = jdpm_pkg::ActSwitch;
        else if (r < 88) act = jdpm_pkg::ActBrake;
        else act = jdpm_pkg::ActBegin;
        pad = (act == jdpm_pkg::ActUpdate) ? ($urandom_range(0, 15) != 0) : 1'($urandom);
        send_item(act, pad, pick_axis(), pick_axis());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
